// ----- hdl/tks_pkg.sv -----
// Shared types and constants of the token scanner.
`default_nettype none
package tks_pkg;

  localparam int POS_BITS   = 16;
  localparam int TOK_W      = 16;
  localparam int MAX_TOK    = 3;
  localparam int FIFO_DEPTH = 4;

  localparam logic [3:0] K_END    = 4'd0;
  localparam logic [3:0] K_AT     = 4'd1;
  localparam logic [3:0] K_COLON  = 4'd2;
  localparam logic [3:0] K_ASSIGN = 4'd3;
  localparam logic [3:0] K_DOT    = 4'd4;
  localparam logic [3:0] K_LPAREN = 4'd5;
  localparam logic [3:0] K_RPAREN = 4'd6;
  localparam logic [3:0] K_COMMA  = 4'd7;
  localparam logic [3:0] K_NUMBER = 4'd8;
  localparam logic [3:0] K_MS     = 4'd9;
  localparam logic [3:0] K_IDENT  = 4'd10;
  localparam logic [3:0] K_STRING = 4'd11;

  typedef struct packed {
    logic [3:0]       kind;
    logic [TOK_W-1:0] start;
    logic [TOK_W-1:0] length;
    logic             last;
  } tok_t;

  typedef struct packed {
    logic [1:0]           cnt;
    tok_t [MAX_TOK-1:0]   tok;
  } push_t;

endpackage
`default_nettype wire

// ----- hdl/tks_fifo.sv -----
// Result queue: takes up to three tokens per cycle, delivers one per transaction.
`default_nettype none
module tks_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire tks_pkg::push_t push,
  output logic                room,
  output logic                out_valid,
  input  wire logic           out_stall,
  output tks_pkg::tok_t       head
);

  localparam int PTR_W = $clog2(tks_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(tks_pkg::FIFO_DEPTH + 1);

  tks_pkg::tok_t mem_r [tks_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic pop;

  assign out_valid = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign room      = (count_r <= CNT_W'(tks_pkg::FIFO_DEPTH - tks_pkg::MAX_TOK));
  assign count_nxt = count_r + CNT_W'(push.cnt) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push.cnt);
      rd_ptr_r <= rd_ptr_r + PTR_W'(pop);
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < tks_pkg::MAX_TOK; i++) begin
      if (2'(i) < push.cnt) begin
        mem_r[wr_ptr_r + PTR_W'(i)] <= push.tok[i];
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(tks_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_with_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> room)
    else $error("push without room");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> count_r == $past(count_nxt))
    else $error("queue count mismatch");

endmodule
`default_nettype wire

// ----- hdl/tks_core.sv -----
// Scanner core: input register, mode and position state, token generation.
`default_nettype none
module tks_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [7:0]     in_char_byte,
  input  wire logic           room,
  output tks_pkg::push_t      push
);

  localparam int PW     = tks_pkg::POS_BITS;
  localparam int CLIP_W = (PW > tks_pkg::TOK_W) ? PW : tks_pkg::TOK_W;
  localparam logic [PW-1:0] POS_MAX = '1;

  typedef enum logic [2:0] {
    M_IDLE, M_DIGITS, M_PEND_M, M_IDENT, M_STRING
  } mode_t;

  typedef struct packed {
    logic          emit;
    logic [3:0]    kind;
    logic [PW-1:0] len;
    mode_t         mode;
    logic          set_beg;
    logic [PW-1:0] beg;
  } idle_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_letter(c) || is_digit(c) || (c == "_");
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic [3:0] punct_kind(input logic [7:0] c);
    logic [3:0] k;
    case (c)
      "@":     k = tks_pkg::K_AT;
      ":":     k = tks_pkg::K_COLON;
      "=":     k = tks_pkg::K_ASSIGN;
      ".":     k = tks_pkg::K_DOT;
      "(":     k = tks_pkg::K_LPAREN;
      ")":     k = tks_pkg::K_RPAREN;
      ",":     k = tks_pkg::K_COMMA;
      default: k = tks_pkg::K_END;
    endcase
    return k;
  endfunction

  function automatic logic [PW-1:0] span(input logic [PW-1:0] from, input logic [PW-1:0] to);
    return (to >= from) ? to - from : '0;
  endfunction

  function automatic logic [tks_pkg::TOK_W-1:0] clip(input logic [PW-1:0] v);
    logic [CLIP_W-1:0] w;
    w = CLIP_W'(v);
    if (w > CLIP_W'({tks_pkg::TOK_W{1'b1}})) begin
      return '1;
    end
    return w[tks_pkg::TOK_W-1:0];
  endfunction

  function automatic tks_pkg::tok_t mk_tok(input logic [3:0] kind, input logic [PW-1:0] start,
                                           input logic [PW-1:0] len);
    tks_pkg::tok_t t;
    t.kind   = kind;
    t.start  = clip(start);
    t.length = clip(len);
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic idle_t idle_eval(input logic [7:0] c, input logic [PW-1:0] p,
                                      input logic [PW-1:0] p_inc);
    idle_t r;
    r.emit    = 1'b0;
    r.kind    = tks_pkg::K_END;
    r.len     = PW'(1);
    r.mode    = M_IDLE;
    r.set_beg = 1'b0;
    r.beg     = p;
    if (c == 8'd0) begin
      r.emit = 1'b1;
      r.len  = '0;
    end else if (is_blank(c)) begin
      r.emit = 1'b0;
    end else if (punct_kind(c) != tks_pkg::K_END) begin
      r.emit = 1'b1;
      r.kind = punct_kind(c);
    end else if (is_digit(c)) begin
      r.mode    = M_DIGITS;
      r.set_beg = 1'b1;
    end else if (is_letter(c) || (c == "_")) begin
      r.mode    = M_IDENT;
      r.set_beg = 1'b1;
    end else if (c == "\"") begin
      r.mode    = M_STRING;
      r.set_beg = 1'b1;
      r.beg     = p_inc;
    end else begin
      r.emit = 1'b1;
      r.kind = tks_pkg::K_IDENT;
    end
    return r;
  endfunction

  logic          in_vld_r;
  logic [7:0]    in_byte_r;
  mode_t         mode_r, mode_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] beg_r, beg_nxt;
  logic [PW-1:0] pos_inc, mpos;
  logic          consume, use_idle;
  logic [1:0]    n;
  idle_t         idl;
  tks_pkg::tok_t [tks_pkg::MAX_TOK-1:0] toks;

  assign consume  = in_vld_r && room;
  assign in_stall = in_vld_r && !room;
  assign pos_inc  = (pos_r == POS_MAX) ? POS_MAX : pos_r + PW'(1);
  assign mpos     = (pos_r > beg_r) ? pos_r - PW'(1) : beg_r;
  assign idl      = idle_eval(in_byte_r, pos_r, pos_inc);

  always_comb begin
    n        = 2'd0;
    toks     = '0;
    mode_nxt = mode_r;
    beg_nxt  = beg_r;
    use_idle = 1'b0;
    case (mode_r)
      M_DIGITS: begin
        if (is_digit(in_byte_r)) begin
          mode_nxt = M_DIGITS;
        end else if (in_byte_r == "m") begin
          mode_nxt = M_PEND_M;
        end else begin
          toks[n] = mk_tok(tks_pkg::K_NUMBER, beg_r, span(beg_r, pos_r));
          n = n + 2'd1;
          use_idle = 1'b1;
        end
      end
      M_PEND_M: begin
        if (in_byte_r == "s") begin
          toks[n] = mk_tok(tks_pkg::K_MS, beg_r, span(beg_r, pos_inc));
          n = n + 2'd1;
          mode_nxt = M_IDLE;
        end else begin
          toks[n] = mk_tok(tks_pkg::K_NUMBER, beg_r, span(beg_r, mpos));
          n = n + 2'd1;
          beg_nxt = mpos;
          if (is_word(in_byte_r)) begin
            mode_nxt = M_IDENT;
          end else begin
            toks[n] = mk_tok(tks_pkg::K_IDENT, mpos, PW'(1));
            n = n + 2'd1;
            use_idle = 1'b1;
          end
        end
      end
      M_IDENT: begin
        if (!is_word(in_byte_r)) begin
          toks[n] = mk_tok(tks_pkg::K_IDENT, beg_r, span(beg_r, pos_r));
          n = n + 2'd1;
          use_idle = 1'b1;
        end
      end
      M_STRING: begin
        if (in_byte_r == "\"") begin
          toks[n] = mk_tok(tks_pkg::K_STRING, beg_r, span(beg_r, pos_r));
          n = n + 2'd1;
          mode_nxt = M_IDLE;
        end else if (in_byte_r == 8'd0) begin
          toks[n] = mk_tok(tks_pkg::K_STRING, beg_r, span(beg_r, pos_r));
          n = n + 2'd1;
          use_idle = 1'b1;
        end
      end
      default: begin
        use_idle = 1'b1;
      end
    endcase
    if (use_idle) begin
      if (idl.emit) begin
        toks[n] = mk_tok(idl.kind, pos_r, idl.len);
        n = n + 2'd1;
      end
      mode_nxt = idl.mode;
      if (idl.set_beg) begin
        beg_nxt = idl.beg;
      end
    end
    if (in_byte_r == 8'd0) begin
      mode_nxt = M_IDLE;
      pos_nxt  = '0;
      beg_nxt  = '0;
    end else begin
      pos_nxt = pos_inc;
    end
    if (n != 2'd0) begin
      toks[n - 2'd1].last = 1'b1;
    end
  end

  assign push.cnt = consume ? n : 2'd0;
  assign push.tok = toks;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      mode_r   <= M_IDLE;
      pos_r    <= '0;
      beg_r    <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        in_vld_r <= 1'b1;
      end else if (consume) begin
        in_vld_r <= 1'b0;
      end
      if (consume) begin
        mode_r <= mode_nxt;
        pos_r  <= pos_nxt;
        beg_r  <= beg_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_char_byte;
    end
  end

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && in_byte_r == 8'd0) |=> (pos_r == '0) && (mode_r == M_IDLE))
    else $error("end byte did not reset position");

  a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && in_byte_r == 8'd0) |->
      (push.cnt != 2'd0) && (push.tok[push.cnt - 2'd1].kind == tks_pkg::K_END))
    else $error("end byte without end token");

  a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (consume && in_byte_r != 8'd0 && pos_r != POS_MAX) |=> pos_r == $past(pos_r) + PW'(1))
    else $error("position did not advance");

endmodule
`default_nettype wire

// ----- hdl/token_scanner.sv -----
// Top level of the token scanner: scanner core feeding the result queue.
//
//   channel  direction  payload                                           handshake
//   in_      input      char_byte[7:0]                                    in_valid / in_stall
//   out_     output     token_kind[3:0] token_start[15:0]                 out_valid / out_stall
//                       token_length[15:0] last_of_run
//
// One byte per cycle enters the input register unless in_stall holds it, and is scanned combinationally.
// A byte yields zero to three tokens, written to a four-entry queue at once.
// Tokens leave one per cycle while out_stall is low; a byte is taken when the queue holds at most one token.
// rst_n (synchronous) empties the queue and returns to idle at position zero.
// out_stall backs up the queue and then holds in_stall high while a byte waits in the input register.
`default_nettype none
module token_scanner (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_token_kind,
  output logic [15:0]      out_token_start,
  output logic [15:0]      out_token_length,
  output logic             out_last_of_run
);

  tks_pkg::push_t push;
  tks_pkg::tok_t  head;
  logic           room;

  tks_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_byte (in_char_byte),
    .room         (room),
    .push         (push)
  );

  tks_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_token_kind   = head.kind;
  assign out_token_start  = head.start;
  assign out_token_length = head.length;
  assign out_last_of_run  = head.last;

endmodule
`default_nettype wire
